FILE: rtl/u8nv_pkg.sv
// Package for the UTF-8 name validator: constants, decoder state and verdict types.
// Has no dependencies; every other file of the block uses it.
`default_nettype none

package u8nv_pkg;

  // Longest name that is still accepted, in bytes.
  localparam int NAME_MAX_BYTES = 63;

  // The byte counter holds values up to NAME_MAX_BYTES + 1.
  localparam int CNT_W = $clog2(NAME_MAX_BYTES + 2);
  // Width of the reported length field.
  localparam int LEN_W = 7;

  // Byte codes used by the decoder.
  localparam logic [7:0] BYTE_TERM      = 8'h00;
  localparam logic [7:0] ASCII_MAX      = 8'h7F;
  localparam logic [7:0] CONT_MASK      = 8'hC0;
  localparam logic [7:0] CONT_TAG       = 8'h80;
  localparam logic [7:0] CONT_LO        = 8'h80;
  localparam logic [7:0] CONT_HI        = 8'hBF;
  localparam logic [7:0] CONT_LO_AFT_E0 = 8'hA0;
  localparam logic [7:0] CONT_HI_AFT_ED = 8'h9F;
  localparam logic [7:0] CONT_LO_AFT_F0 = 8'h90;
  localparam logic [7:0] CONT_HI_AFT_F4 = 8'h8F;
  localparam logic [7:0] LEAD2_LO       = 8'hC2;
  localparam logic [7:0] LEAD2_HI       = 8'hDF;
  localparam logic [7:0] LEAD3_LO       = 8'hE0;
  localparam logic [7:0] LEAD3_HI       = 8'hEF;
  localparam logic [7:0] LEAD3_SURR     = 8'hED;
  localparam logic [7:0] LEAD4_LO       = 8'hF0;
  localparam logic [7:0] LEAD4_HI       = 8'hF4;

  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {
    CLS_NORMAL   = 3'd0,
    CLS_AFTER_E0 = 3'd1,
    CLS_AFTER_ED = 3'd2,
    CLS_AFTER_F0 = 3'd3,
    CLS_AFTER_F4 = 3'd4
  } range_cls_e;

  typedef struct packed {
    logic [1:0]       pend;
    range_cls_e       cls;
    logic             err;
    logic [CNT_W-1:0] cnt;
  } dec_state_t;

  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] len;
  } verdict_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    pend: 2'd0,
    cls:  CLS_NORMAL,
    err:  1'b0,
    cnt:  '0
  };

endpackage

`default_nettype wire

FILE: rtl/u8nv_step.sv
// Next-state and verdict logic of the UTF-8 name decoder for one byte.
// Depends on u8nv_pkg.
`default_nettype none

module u8nv_step (
  input  var u8nv_pkg::dec_state_t cur_i,
  input  wire logic [7:0]          byte_i,
  output u8nv_pkg::dec_state_t     nxt_o,
  output u8nv_pkg::verdict_t       verdict_o
);

  logic                                          cont_ok;
  logic                                          cnt_ok;
  logic [u8nv_pkg::CNT_W+u8nv_pkg::LEN_W-1:0]    cnt_ext;

  always_comb begin
    case (cur_i.cls)
      u8nv_pkg::CLS_AFTER_E0:
        cont_ok = (byte_i >= u8nv_pkg::CONT_LO_AFT_E0) && (byte_i <= u8nv_pkg::CONT_HI);
      u8nv_pkg::CLS_AFTER_ED:
        cont_ok = (byte_i >= u8nv_pkg::CONT_LO) && (byte_i <= u8nv_pkg::CONT_HI_AFT_ED);
      u8nv_pkg::CLS_AFTER_F0:
        cont_ok = (byte_i >= u8nv_pkg::CONT_LO_AFT_F0) && (byte_i <= u8nv_pkg::CONT_HI);
      u8nv_pkg::CLS_AFTER_F4:
        cont_ok = (byte_i >= u8nv_pkg::CONT_LO) && (byte_i <= u8nv_pkg::CONT_HI_AFT_F4);
      default:
        cont_ok = (byte_i & u8nv_pkg::CONT_MASK) == u8nv_pkg::CONT_TAG;
    endcase
  end

  assign cnt_ok = cur_i.cnt <= u8nv_pkg::CNT_W'(u8nv_pkg::NAME_MAX_BYTES);

  always_comb begin
    nxt_o = cur_i;
    if (byte_i == u8nv_pkg::BYTE_TERM) begin
      nxt_o = u8nv_pkg::DEC_STATE_RESET;
    end else begin
      if (cnt_ok) begin
        nxt_o.cnt = cur_i.cnt + u8nv_pkg::CNT_W'(1);
      end
      nxt_o.cls = u8nv_pkg::CLS_NORMAL;
      if (cur_i.pend != 2'd0) begin
        // A rejected continuation drops the open sequence without re-decoding it.
        if (!cont_ok) begin
          nxt_o.err  = 1'b1;
          nxt_o.pend = 2'd0;
        end else begin
          nxt_o.pend = cur_i.pend - 2'd1;
        end
      end else if (byte_i <= u8nv_pkg::ASCII_MAX) begin
        nxt_o.pend = 2'd0;
      end else if ((byte_i >= u8nv_pkg::LEAD2_LO) && (byte_i <= u8nv_pkg::LEAD2_HI)) begin
        nxt_o.pend = 2'd1;
      end else if ((byte_i >= u8nv_pkg::LEAD3_LO) && (byte_i <= u8nv_pkg::LEAD3_HI)) begin
        nxt_o.pend = 2'd2;
        if (byte_i == u8nv_pkg::LEAD3_LO) begin
          nxt_o.cls = u8nv_pkg::CLS_AFTER_E0;
        end else if (byte_i == u8nv_pkg::LEAD3_SURR) begin
          nxt_o.cls = u8nv_pkg::CLS_AFTER_ED;
        end
      end else if ((byte_i >= u8nv_pkg::LEAD4_LO) && (byte_i <= u8nv_pkg::LEAD4_HI)) begin
        nxt_o.pend = 2'd3;
        if (byte_i == u8nv_pkg::LEAD4_LO) begin
          nxt_o.cls = u8nv_pkg::CLS_AFTER_F0;
        end else if (byte_i == u8nv_pkg::LEAD4_HI) begin
          nxt_o.cls = u8nv_pkg::CLS_AFTER_F4;
        end
      end else begin
        nxt_o.err = 1'b1;
      end
    end
  end

  assign cnt_ext       = {u8nv_pkg::LEN_W'(0), cur_i.cnt};
  assign verdict_o.ok  = !cur_i.err && (cur_i.pend == 2'd0) && cnt_ok;
  assign verdict_o.len = cnt_ext[u8nv_pkg::LEN_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/u8nv_outreg.sv
// Result register of the UTF-8 name validator with its valid flag.
// Depends on u8nv_pkg.
`default_nettype none

module u8nv_outreg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  var u8nv_pkg::verdict_t  verdict_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output u8nv_pkg::verdict_t      verdict_o
);

  logic               valid_q, valid_d;
  u8nv_pkg::verdict_t verdict_q;

  // The loader only loads when the register is empty or being drained.
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign out_valid_o = valid_q;
  assign verdict_o   = verdict_q;

endmodule

`default_nettype wire

FILE: rtl/utf8_name_validator_top.sv
// Top level of the UTF-8 name validator: input register, decoder state, result register.
// Depends on u8nv_pkg, u8nv_step and u8nv_outreg.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+------------------------------
//   in      | in_valid_i / in_ready_o   | byte_value_i[7:0]
//   out     | out_valid_o / out_ready_i | name_ok_o, name_length_o[6:0]
//
// One byte is taken per cycle while in_ready_o is high. A byte is held in the input register
// and then updates the decoder state; a terminator also loads the verdict into the result
// register as it leaves the input register. Reset clears the input register's valid flag,
// the decoder state and the result valid flag. A stall on the output holds back only a
// terminator; ordinary bytes keep flowing until a terminator waits in the input register.
`default_nettype none

module utf8_name_validator_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_value_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            name_ok_o,
  output logic [6:0]      name_length_o
);

  // Input register stage.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_term;
  logic       s1_adv;
  logic       in_xfer;

  // Decoder state, updated once per byte leaving the input register.
  u8nv_pkg::dec_state_t state_q, state_d;
  u8nv_pkg::verdict_t   verdict;
  u8nv_pkg::verdict_t   out_verdict;
  logic                 load_result;

  assign s1_term = s1_byte_q == u8nv_pkg::BYTE_TERM;

  // A terminator may leave only when the result register can take its verdict.
  assign s1_adv     = s1_valid_q && (!s1_term || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= byte_value_i;
    end
  end

  u8nv_step u_step (
    .cur_i     (state_q),
    .byte_i    (s1_byte_q),
    .nxt_o     (state_d),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u8nv_pkg::DEC_STATE_RESET;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  assign load_result = s1_adv && s1_term;

  u8nv_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load_result),
    .verdict_i   (verdict),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .verdict_o   (out_verdict)
  );

  assign name_ok_o     = out_verdict.ok;
  assign name_length_o = out_verdict.len;

  // A narrowed continuation range only exists while a sequence is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.cls != u8nv_pkg::CLS_NORMAL) |-> (state_q.pend != 2'd0))
    else $error("narrowed range class without an open sequence");

  // The byte counter never passes its saturation value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cnt <= u8nv_pkg::CNT_W'(u8nv_pkg::NAME_MAX_BYTES + 1))
    else $error("byte counter beyond saturation");

  // A terminator that leaves the input register yields a verdict and clears the name.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> (out_valid_o && (state_q.cnt == '0) && !state_q.err))
    else $error("terminator did not produce a verdict or clear the state");

  // A verdict that reports success never carries an over-long count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_result && verdict.ok) |->
      (state_q.cnt <= u8nv_pkg::CNT_W'(u8nv_pkg::NAME_MAX_BYTES)))
    else $error("accepted name longer than the limit");

endmodule

`default_nettype wire

FILE: tb/sv/utf8_name_validator_top_tb.sv
// Self-checking testbench for utf8_name_validator_top: feeds zero-terminated names one byte
// per transfer and checks every verdict against a built-in UTF-8 decoder scoreboard.
// Depends on u8nv_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module utf8_name_validator_top_tb;
  import u8nv_pkg::*;

  // Roughly how many bytes the whole run offers to the block.
  localparam int ITEM_TARGET = 1100;
  // Length of the deliberate output back-pressure window, in clock cycles.
  localparam int HOLD_CYCLES = 300;
  // Extra cycles after the last verdict; the verdict path is two registers deep.
  localparam int TAIL_CYCLES = 8;

  localparam logic [7:0] ASCII_MIN    = 8'h01;
  localparam logic [7:0] BYTE_MAX     = 8'hFF;
  localparam logic [7:0] BAD_LEAD2_HI = LEAD2_LO - 8'd1;
  localparam logic [7:0] BAD_LEAD4_LO = LEAD4_HI + 8'd1;

  // Scoreboard: runs its own copy of the decoder state on every accepted byte and
  // queues the verdict that each terminator must produce.
  class verdict_board;
    logic [1:0]  pend;
    range_cls_e  cls;
    bit          err;
    int unsigned cnt;
    verdict_t    due[$];
    int unsigned failures;

    function new();
      failures = 0;
      clear_name();
    endfunction

    function void clear_name();
      pend = 2'd0;
      cls  = CLS_NORMAL;
      err  = 1'b0;
      cnt  = 0;
    endfunction

    function bit cont_fits(logic [7:0] b);
      case (cls)
        CLS_AFTER_E0: return b >= CONT_LO_AFT_E0 && b <= CONT_HI;
        CLS_AFTER_ED: return b >= CONT_LO && b <= CONT_HI_AFT_ED;
        CLS_AFTER_F0: return b >= CONT_LO_AFT_F0 && b <= CONT_HI;
        CLS_AFTER_F4: return b >= CONT_LO && b <= CONT_HI_AFT_F4;
        default:      return (b & CONT_MASK) == CONT_TAG;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      verdict_t v;
      if (b == BYTE_TERM) begin
        v.ok  = !err && pend == 2'd0 && cnt <= NAME_MAX_BYTES;
        v.len = LEN_W'(cnt);
        due.push_back(v);
        clear_name();
        return;
      end
      if (cnt <= NAME_MAX_BYTES) cnt++;
      if (pend != 2'd0) begin
        // A rejected continuation drops the open sequence; it is not retried as a lead.
        if (!cont_fits(b)) begin
          err  = 1'b1;
          pend = 2'd0;
        end else begin
          pend = pend - 2'd1;
        end
        cls = CLS_NORMAL;
        return;
      end
      cls = CLS_NORMAL;
      if (b <= ASCII_MAX) return;
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        pend = 2'd1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        pend = 2'd2;
        if (b == LEAD3_LO) cls = CLS_AFTER_E0;
        else if (b == LEAD3_SURR) cls = CLS_AFTER_ED;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        pend = 2'd3;
        if (b == LEAD4_LO) cls = CLS_AFTER_F0;
        else if (b == LEAD4_HI) cls = CLS_AFTER_F4;
      end else begin
        err = 1'b1;
      end
    endfunction

    function void check_verdict(logic ok, logic [LEN_W-1:0] len);
      verdict_t want;
      if (due.size() == 0) begin
        $error("verdict ok=%0b len=%0d arrived with no name pending", ok, len);
        failures++;
        return;
      end
      want = due.pop_front();
      if (ok !== want.ok) begin
        $error("name_ok: expected %0b, got %0b", want.ok, ok);
        failures++;
      end
      if (len !== want.len) begin
        $error("name_length: expected %0d, got %0d", want.len, len);
        failures++;
      end
    endfunction

    function int due_count();
      return due.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] byte_value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       name_ok_o;
  logic [6:0] name_length_o;

  verdict_board board;
  logic [7:0]   name_q[$];     // bytes of the name being offered next
  int           bytes_sent;
  bit           tx_gaps_on;    // sender inserts random idle cycles
  bit           rx_gaps_on;    // receiver drops ready at random
  int           hold_asked;    // sender bumps this to request a long output stall
  int           hold_served;

  utf8_name_validator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .name_ok_o     (name_ok_o),
    .name_length_o (name_length_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Byte generators. Each one appends to name_q; the terminator is added by the
  // caller so that a name can also end in the middle of a sequence.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_in(logic [7:0] lo, logic [7:0] hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // Lead byte for an n-byte sequence, biased toward the leads that narrow the
  // range of the following continuation byte.
  function automatic logic [7:0] pick_lead(int n);
    int coin;
    coin = $urandom_range(0, 3);
    if (n == 2) return pick_in(LEAD2_LO, LEAD2_HI);
    if (n == 3) begin
      if (coin == 0) return LEAD3_LO;
      if (coin == 1) return LEAD3_SURR;
      return pick_in(LEAD3_LO, LEAD3_HI);
    end
    if (coin == 0) return LEAD4_LO;
    if (coin == 1) return LEAD4_HI;
    return pick_in(LEAD4_LO, LEAD4_HI);
  endfunction

  // Legal range of the first continuation byte after a given lead.
  function automatic void first_range(input logic [7:0] lead,
                                      output logic [7:0] lo, output logic [7:0] hi);
    lo = CONT_LO;
    hi = CONT_HI;
    if (lead == LEAD3_LO) lo = CONT_LO_AFT_E0;
    else if (lead == LEAD3_SURR) hi = CONT_HI_AFT_ED;
    else if (lead == LEAD4_LO) lo = CONT_LO_AFT_F0;
    else if (lead == LEAD4_HI) hi = CONT_HI_AFT_F4;
  endfunction

  // One well-formed character of one to four bytes.
  function automatic void push_good_char();
    int         n;
    logic [7:0] lead, lo, hi;
    n = $urandom_range(1, 4);
    if (n == 1) begin
      name_q.push_back(pick_in(ASCII_MIN, ASCII_MAX));
      return;
    end
    lead = pick_lead(n);
    first_range(lead, lo, hi);
    name_q.push_back(lead);
    name_q.push_back(pick_in(lo, hi));
    repeat (n - 2) name_q.push_back(pick_in(CONT_LO, CONT_HI));
  endfunction

  // One malformed fragment: plain noise, an illegal lead, a first continuation
  // outside its range, or a sequence that stops early and lets the next byte break it.
  function automatic void push_bad_char();
    logic [7:0] lead, lo, hi, b;
    case ($urandom_range(0, 3))
      0: name_q.push_back(pick_in(ASCII_MIN, BYTE_MAX));
      1: begin
        if ($urandom_range(0, 1) == 0) name_q.push_back(pick_in(CONT_LO, BAD_LEAD2_HI));
        else name_q.push_back(pick_in(BAD_LEAD4_LO, BYTE_MAX));
      end
      2: begin
        lead = pick_lead($urandom_range(2, 4));
        first_range(lead, lo, hi);
        do b = pick_in(ASCII_MIN, BYTE_MAX); while (b >= lo && b <= hi);
        name_q.push_back(lead);
        name_q.push_back(b);
      end
      default: begin
        lead = pick_lead($urandom_range(3, 4));
        first_range(lead, lo, hi);
        name_q.push_back(lead);
        name_q.push_back(pick_in(lo, hi));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Every call starts and ends at a falling edge. Valid stays high
  // from one byte to the next unless an idle cycle is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    while (tx_gaps_on && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_name();
    foreach (name_q[i]) send_byte(name_q[i]);
  endtask

  // Stops offering bytes until every pending verdict has been seen.
  task automatic wait_for_verdicts();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.due_count() != 0);
  endtask

  task automatic send_random_name();
    int shape;
    shape = $urandom_range(0, 99);
    name_q.delete();
    if (shape < 2) begin
      // Plain ASCII right around the length limit.
      repeat ($urandom_range(NAME_MAX_BYTES - 1, NAME_MAX_BYTES + 2))
        name_q.push_back(pick_in(ASCII_MIN, ASCII_MAX));
    end else begin
      // Mostly short names; a few long ones that can run past the limit.
      repeat ((shape < 5) ? $urandom_range(20, 40) : $urandom_range(0, 8)) begin
        if ($urandom_range(0, 99) < 85) push_good_char();
        else push_bad_char();
      end
      // Now and then the terminator cuts a sequence short.
      if ($urandom_range(0, 99) < 6) name_q.push_back(pick_lead($urandom_range(2, 4)));
    end
    name_q.push_back(BYTE_TERM);
    send_name();
  endtask

  // ---------------------------------------------------------------------------
  // Output side. Ready changes only at falling edges. A hold request from the
  // stimulus process keeps ready low for HOLD_CYCLES, counted here.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    out_ready_i = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= !(rx_gaps_on && $urandom_range(0, 99) < 8);
    end
  end

  // Every verdict transfer is checked at the rising edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      board.check_verdict(name_ok_o, name_length_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    board        = new();
    bytes_sent   = 0;
    hold_asked   = 0;
    tx_gaps_on   = 1'b1;
    rx_gaps_on   = 1'b1;
    in_valid_i   = 1'b0;
    byte_value_i = 8'h00;
    rst_ni       = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed names. An empty name first. Then one valid name that walks the ASCII
    // extremes and every lead class, each narrowed continuation at its legal edge.
    name_q = '{BYTE_TERM};
    send_name();
    name_q = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80,
               8'hED, 8'h9F, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F,
               8'hBF, 8'hBF, BYTE_TERM};
    send_name();
    // A surrogate, and a three-byte sequence cut off by the terminator.
    name_q = '{8'hED, 8'hA0, BYTE_TERM};
    send_name();
    name_q = '{8'hE1, 8'h80, BYTE_TERM};
    send_name();
    // An illegal lead byte just below the two-byte range.
    name_q = '{BAD_LEAD2_HI, BYTE_TERM};
    send_name();
    wait_for_verdicts();

    // Random names with idle cycles on both sides.
    while (bytes_sent < 400) send_random_name();

    // A long stretch at full rate in both directions.
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    while (bytes_sent < 700) send_random_name();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;

    // Stall the output while short, terminator-heavy names keep coming, so that
    // pending verdicts back up and the block has to stop taking bytes.
    hold_asked++;
    repeat (30) begin
      name_q.delete();
      repeat ($urandom_range(0, 2)) push_good_char();
      name_q.push_back(BYTE_TERM);
      send_name();
    end

    // The rest of the random part, pausing now and then until all verdicts are in.
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 3) wait_for_verdicts();
      send_random_name();
    end

    wait_for_verdicts();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (board.due_count() != 0) begin
      $error("%0d verdicts never arrived", board.due_count());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // This time bound lies far beyond the length of a normal run.
  initial begin : watchdog
    #200000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: utf8_name_validator_top.f
rtl/u8nv_pkg.sv
rtl/u8nv_step.sv
rtl/u8nv_outreg.sv
rtl/utf8_name_validator_top.sv
tb/sv/utf8_name_validator_top_tb.sv
